@@ hdl/dfrd_pkg.sv @@
// dfrd_pkg: shared types, opcodes and sizes for the delta-frame run-length decoder
`default_nettype none
package dfrd_pkg;

  // default frame size in words
  localparam int unsigned FRAME_WORDS_DEF = 32768;

  // field widths
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned PTR_W   = 18;
  localparam int unsigned SUM_W   = PTR_W + 1;

  // opcodes
  localparam logic [7:0] OP_END        = 8'h00;
  localparam logic [7:0] OP_END_ALT    = 8'h13;
  localparam logic [7:0] OP_SKIP1      = 8'h02;
  localparam logic [7:0] OP_SKIP8      = 8'h03;
  localparam logic [7:0] OP_SKIP16     = 8'h04;
  localparam logic [7:0] OP_COPY_FIRST = 8'h06;
  localparam logic [7:0] OP_COPY_LAST  = 8'h0a;
  localparam logic [7:0] OP_COPY8      = 8'h0b;
  localparam logic [7:0] OP_COPY16     = 8'h0c;
  localparam logic [7:0] OP_FILL_FIRST = 8'h0d;
  localparam logic [7:0] OP_FILL_LAST  = 8'h10;
  localparam logic [7:0] OP_FILL8      = 8'h11;
  localparam logic [7:0] OP_FILL16     = 8'h12;

  // offsets that turn short copy / fill opcodes into run lengths
  localparam logic [7:0] COPY_BASE = 8'h05;
  localparam logic [7:0] FILL_BASE = 8'h0b;

  // parser phases
  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_CNT8,
    PH_CNT_LO,
    PH_CNT_HI,
    PH_WORD_LO,
    PH_WORD_HI
  } dfrd_phase_t;

  // one result word
  typedef struct packed {
    logic [ADDR_W-1:0]  word_addr;
    logic [COUNT_W-1:0] word_count;
    logic [VALUE_W-1:0] word_value;
    logic               frame_end;
    logic               out_of_range;
  } dfrd_result_t;

endpackage
`default_nettype wire

@@ hdl/dfrd_parser.sv @@
// dfrd_parser: byte parser state and burst / frame-end result generation
`default_nettype none
module dfrd_parser
  import dfrd_pkg::*;
#(
  parameter int unsigned FRAME_WORDS = FRAME_WORDS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire logic [7:0]   in_byte,
  output logic              res_valid,
  output dfrd_result_t      res
);

  localparam logic [SUM_W-1:0] FRAME_LIM = SUM_W'(FRAME_WORDS);

  dfrd_phase_t        phase_r, phase_nxt;
  logic [7:0]         opcode_r, opcode_nxt;
  logic [7:0]         low_byte_r, low_byte_nxt;
  logic [COUNT_W-1:0] run_count_r, run_count_nxt;
  logic [PTR_W-1:0]   word_ptr_r, word_ptr_nxt;

  logic               adv_en;
  logic               emit;
  logic               end_hit;
  logic [COUNT_W-1:0] adv_amt;
  logic [VALUE_W-1:0] burst_value;
  logic [VALUE_W-1:0] word16;
  logic [COUNT_W-1:0] rc_dec;
  logic [SUM_W-1:0]   ptr_sum;
  logic               is_literal;

  assign word16     = {in_byte, low_byte_r};
  assign is_literal = (opcode_r >= OP_COPY_FIRST) && (opcode_r <= OP_COPY16);
  assign rc_dec     = (run_count_r != '0) ? run_count_r - COUNT_W'(1) : '0;
  assign ptr_sum    = SUM_W'(word_ptr_r) + SUM_W'(adv_amt);

  // phase decode and next state
  always_comb begin
    phase_nxt     = phase_r;
    opcode_nxt    = opcode_r;
    low_byte_nxt  = low_byte_r;
    run_count_nxt = run_count_r;
    adv_en        = 1'b0;
    emit          = 1'b0;
    end_hit       = 1'b0;
    adv_amt       = '0;
    burst_value   = '0;
    unique case (phase_r)
      PH_CNT8: begin
        phase_nxt = PH_OPCODE;
        if (opcode_r == OP_SKIP8) begin
          adv_en  = 1'b1;
          adv_amt = COUNT_W'(in_byte) + COUNT_W'(1);
        end else begin
          run_count_nxt = COUNT_W'(in_byte) + COUNT_W'(1);
          phase_nxt     = PH_WORD_LO;
        end
      end
      PH_CNT_LO: begin
        low_byte_nxt = in_byte;
        phase_nxt    = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        phase_nxt = PH_OPCODE;
        if (opcode_r == OP_SKIP16) begin
          adv_en  = 1'b1;
          adv_amt = COUNT_W'(word16) + COUNT_W'(1);
        end else begin
          run_count_nxt = COUNT_W'(word16) + COUNT_W'(1);
          phase_nxt     = PH_WORD_LO;
        end
      end
      PH_WORD_LO: begin
        low_byte_nxt = in_byte;
        phase_nxt    = PH_WORD_HI;
      end
      PH_WORD_HI: begin
        adv_en      = 1'b1;
        emit        = 1'b1;
        burst_value = word16;
        if (is_literal) begin
          // literal copy: one word per burst
          run_count_nxt = rc_dec;
          phase_nxt     = (rc_dec == '0) ? PH_OPCODE : PH_WORD_LO;
          adv_amt       = COUNT_W'(1);
        end else begin
          run_count_nxt = '0;
          phase_nxt     = PH_OPCODE;
          adv_amt       = run_count_r;
        end
      end
      default: begin
        // waiting for opcode
        phase_nxt  = PH_OPCODE;
        opcode_nxt = in_byte;
        if (in_byte == OP_END || in_byte == OP_END_ALT) begin
          end_hit = 1'b1;
        end else if (in_byte == OP_SKIP1) begin
          adv_en  = 1'b1;
          adv_amt = COUNT_W'(1);
        end else if (in_byte == OP_SKIP8 || in_byte == OP_COPY8 || in_byte == OP_FILL8) begin
          phase_nxt = PH_CNT8;
        end else if (in_byte == OP_SKIP16 || in_byte == OP_COPY16 ||
                     in_byte == OP_FILL16) begin
          phase_nxt = PH_CNT_LO;
        end else if (in_byte >= OP_COPY_FIRST && in_byte <= OP_COPY_LAST) begin
          run_count_nxt = COUNT_W'(in_byte - COPY_BASE);
          phase_nxt     = PH_WORD_LO;
        end else if (in_byte >= OP_FILL_FIRST && in_byte <= OP_FILL_LAST) begin
          run_count_nxt = COUNT_W'(in_byte - FILL_BASE);
          phase_nxt     = PH_WORD_LO;
        end
      end
    endcase
  end

  // pointer update and result forming
  always_comb begin
    word_ptr_nxt = word_ptr_r;
    res_valid    = emit || end_hit;
    res          = '0;
    if (end_hit) begin
      word_ptr_nxt  = '0;
      res.frame_end = 1'b1;
    end else if (adv_en) begin
      word_ptr_nxt = ptr_sum[PTR_W] ? {PTR_W{1'b1}} : ptr_sum[PTR_W-1:0];
    end
    if (emit) begin
      if (ptr_sum > FRAME_LIM) begin
        res.out_of_range = 1'b1;
      end else begin
        res.word_addr  = word_ptr_r[ADDR_W-1:0];
        res.word_count = adv_amt;
        res.word_value = burst_value;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      opcode_r    <= '0;
      low_byte_r  <= '0;
      run_count_r <= '0;
      word_ptr_r  <= '0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      opcode_r    <= opcode_nxt;
      low_byte_r  <= low_byte_nxt;
      run_count_r <= run_count_nxt;
      word_ptr_r  <= word_ptr_nxt;
    end
  end

  // frame end and range flag never come together
  a_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res.frame_end && res.out_of_range))
    else $error("frame end flagged out of range");

  // pointer is back at the frame start after a frame end
  a_end_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_valid && res.frame_end) |=> (word_ptr_r == '0))
    else $error("pointer not cleared on frame end");

  // a result only comes from the second byte of a word or an opcode
  a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (phase_r == PH_WORD_HI || res.frame_end))
    else $error("result from a count or low byte phase");

endmodule
`default_nettype wire

@@ hdl/dfrd_out_buf.sv @@
// dfrd_out_buf: two-deep result buffer with registered upstream ready
`default_nettype none
module dfrd_out_buf
  import dfrd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dfrd_result_t  push_data,
  output logic               can_take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dfrd_result_t       out_data
);

  logic         main_valid_r;
  logic         skid_valid_r;
  dfrd_result_t main_r;
  dfrd_result_t skid_r;
  logic         pop;

  assign pop       = main_valid_r && out_ready;
  assign can_take  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // result words
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

  // the skid stage only fills behind a full output stage
  a_skid_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word without output word");

  // a stalled push lands in the skid stage
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && main_valid_r && !out_ready && !skid_valid_r) |=> skid_valid_r)
    else $error("stalled word dropped");

  // the skid stage drains on a taken word
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (!skid_valid_r && main_valid_r))
    else $error("skid stage not drained");

endmodule
`default_nettype wire

@@ hdl/delta_frame_rle_decoder_unit.sv @@
// delta_frame_rle_decoder_unit: top level of the delta-frame run-length decoder
//
//   port group  direction  contents
//   in_*        input      one stream byte per word (in_byte)
//   out_*       output     write burst or frame-end marker per word
//
// One byte is taken per clock while in_ready is high; each burst is registered
// in the two-deep result buffer before it leaves on out_*.
// in_ready falls only while both result stages are full.
// Synchronous active-low reset clears the parser and empties the buffer.
// Bytes are still taken while out_ready is low, until both stages hold a word.
`default_nettype none
module delta_frame_rle_decoder_unit
  import dfrd_pkg::*;
#(
  parameter int unsigned FRAME_WORDS = FRAME_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ADDR_W-1:0]       out_word_addr,
  output logic [COUNT_W-1:0]      out_word_count,
  output logic [VALUE_W-1:0]      out_word_value,
  output logic                    out_frame_end,
  output logic                    out_out_of_range
);

  logic         acc;
  logic         res_valid;
  dfrd_result_t res;
  dfrd_result_t out_data;

  assign acc = in_valid && in_ready;

  // byte parser
  dfrd_parser #(
    .FRAME_WORDS(FRAME_WORDS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // result buffer
  dfrd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_valid),
    .push_data (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_word_addr    = out_data.word_addr;
  assign out_word_count   = out_data.word_count;
  assign out_word_value   = out_data.word_value;
  assign out_frame_end    = out_data.frame_end;
  assign out_out_of_range = out_data.out_of_range;

endmodule
`default_nettype wire
